// ----- hdl/ghi_pkg.sv -----
// ---------------------------------------------------------------------------
// ghi_pkg: shared types and constants of the gyro heading integrator
// Field widths, the opcode values and the item record that travels between
// the input stage and the integrator.
// ---------------------------------------------------------------------------
package ghi_pkg;

  // Field and state widths, fixed by the sample and result formats.
  localparam int RATE_W  = 16;
  localparam int TS_W    = 32;
  localparam int ACC_W   = 48;
  localparam int SUM_W   = 24;
  localparam int DRIFT_W = 24;
  localparam int CNT_W   = 7;
  localparam int THR_W   = 24;

  // Dead-band threshold after reset, 0.05 degree in 1/256 LSB-ms units.
  localparam logic [THR_W-1:0] THR_RESET = 24'd1676800;

  // Item opcodes.
  localparam logic OP_CALIB  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // One input item.
  typedef struct packed {
    logic                     opcode;
    logic signed [RATE_W-1:0] rate_sample;
    logic [TS_W-1:0]          timestamp_ms;
  } ghi_item_t;

endpackage

// ----- hdl/gyro_heading_integrator_unit.sv -----
// ---------------------------------------------------------------------------
// gyro_heading_integrator_unit: gyro heading integrator top level
// Integrates z-axis gyro rate samples into a heading, with drift calibration.
// ---------------------------------------------------------------------------
// Usage:
// Samples enter on the in_valid/in_ready channel, one transaction each, with
// opcode selecting a calibration sample or a heading update. Every sample
// gives exactly one result on out_valid/out_ready: the heading after that
// sample and the calibrated flag. A taken sample is held in the input
// register, and its result is written into the output register once that
// register is free. Throughput is one sample per cycle while the receiver
// does not stall: the drift subtract, the rate-times-dt multiplier, the
// dead-band compare and the accumulator add are all combinational between
// the input and output registers, as is the reciprocal multiplier that
// turns a calibration sum into its mean.
// When the receiver stalls, the result holds in the output register and one
// more sample may wait in the input register; in_ready then drops.
// The user must write the dead-band threshold on cfg_valid/cfg_data only
// while idle; the block itself does not enforce this.
// Synchronous reset clears the drift, the calibration run, the last update
// time and the heading, and restores the default threshold.
// ---------------------------------------------------------------------------
module gyro_heading_integrator_unit #(
  parameter int CAL_SAMPLES = 100,
  parameter int DT_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic signed [ghi_pkg::RATE_W-1:0] rate_sample,
  input  logic [ghi_pkg::TS_W-1:0]          timestamp_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ghi_pkg::ACC_W-1:0]  heading,
  output logic                              calibrated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ghi_pkg::THR_W-1:0]         cfg_data
);

  ghi_pkg::ghi_item_t                item_in;
  ghi_pkg::ghi_item_t                item;
  logic                              held_valid;
  logic                              out_free;
  logic                              fire;
  logic                              calib_fire;
  logic                              update_fire;
  logic [ghi_pkg::THR_W-1:0]         threshold;
  logic signed [ghi_pkg::DRIFT_W-1:0] drift_q8;
  logic                              is_calibrated;
  logic                              calibrated_next;
  logic signed [ghi_pkg::ACC_W-1:0]  angle;
  logic signed [ghi_pkg::ACC_W-1:0]  angle_next;

  // Dead-band threshold register; writes are always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ghi_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Input register.
  assign item_in.opcode       = opcode;
  assign item_in.rate_sample  = rate_sample;
  assign item_in.timestamp_ms = timestamp_ms;

  assign out_free = !out_valid || out_ready;
  assign fire     = held_valid && out_free;

  ghi_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (out_free),
    .held_valid (held_valid),
    .item       (item)
  );

  // Route the held item to calibration or integration.
  assign calib_fire  = fire && (item.opcode == ghi_pkg::OP_CALIB);
  assign update_fire = fire && (item.opcode == ghi_pkg::OP_UPDATE);

  ghi_calib_unit #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_calib (
    .clk             (clk),
    .rst             (rst),
    .fire            (calib_fire),
    .rate            (item.rate_sample),
    .drift_q8        (drift_q8),
    .is_calibrated   (is_calibrated),
    .calibrated_next (calibrated_next)
  );

  ghi_integ_unit #(
    .DT_BITS (DT_BITS)
  ) u_integ (
    .clk        (clk),
    .rst        (rst),
    .fire       (update_fire),
    .rate       (item.rate_sample),
    .timestamp  (item.timestamp_ms),
    .drift_q8   (drift_q8),
    .threshold  (threshold),
    .angle      (angle),
    .angle_next (angle_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      heading    <= angle_next;
      calibrated <= calibrated_next;
    end
  end

  // A processed item always leaves a result behind.
  assert property (@(posedge clk) disable iff (rst) fire |=> out_valid)
    else $error("processed item did not produce a result");

  // A calibration sample never moves the heading.
  assert property (@(posedge clk) disable iff (rst) calib_fire |=> $stable(angle))
    else $error("calibration sample changed the accumulator");

  // Once calibrated, the block stays calibrated until reset.
  assert property (@(posedge clk)
    (!rst && $past(!rst) && $past(is_calibrated)) |-> is_calibrated)
    else $error("calibrated flag dropped without reset");

  // The result carries the accumulator as it stood after the item.
  assert property (@(posedge clk) disable iff (rst) fire |=> (heading == angle))
    else $error("reported heading differs from the accumulator");

endmodule

// ----- hdl/ghi_input_stage.sv -----
// ---------------------------------------------------------------------------
// ghi_input_stage: input register of the heading integrator
// Holds one accepted item until the result register can take its result.
// ---------------------------------------------------------------------------
module ghi_input_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ghi_pkg::ghi_item_t item_in,
  input  logic              advance,
  output logic              held_valid,
  output ghi_pkg::ghi_item_t item
);

  // The stage is free when empty or when its item moves on this cycle.
  assign in_ready = !held_valid || advance;

  // Valid flag of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload capture on each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

// ----- hdl/ghi_calib_unit.sv -----
// ---------------------------------------------------------------------------
// ghi_calib_unit: gyro drift calibration
// Sums a run of calibration samples and, on the last one, sets the drift
// to the run mean in Q8, truncated toward zero.
// ---------------------------------------------------------------------------
module ghi_calib_unit #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic signed [ghi_pkg::RATE_W-1:0]  rate,
  output logic signed [ghi_pkg::DRIFT_W-1:0] drift_q8,
  output logic                               is_calibrated,
  output logic                               calibrated_next
);

  // The mean is |sum| * 256 / CAL_SAMPLES. With |sum| * 256 below 2^30 and
  // CAL_SAMPLES below 2^7, a rounded-up reciprocal at 2^37 gives the exact
  // floor; the factor 256 folds into the shift.
  localparam int REC_SHIFT = 37;
  localparam int REC_W     = REC_SHIFT + 1;
  localparam int Q_SHIFT   = REC_SHIFT - 8;
  localparam int PROD_W    = ghi_pkg::SUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((64'd1 << REC_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [ghi_pkg::CNT_W-1:0] RUN_LEN = ghi_pkg::CNT_W'(CAL_SAMPLES);

  logic signed [ghi_pkg::SUM_W-1:0]   rate_sum;
  logic [ghi_pkg::CNT_W-1:0]          cal_count;
  logic signed [ghi_pkg::SUM_W-1:0]   sum_next;
  logic [ghi_pkg::CNT_W-1:0]          cal_count_next;
  logic                               run_done;
  logic [ghi_pkg::SUM_W-1:0]          sum_mag;
  logic [PROD_W-1:0]                  prod;
  logic [ghi_pkg::DRIFT_W-1:0]        quot;
  logic signed [ghi_pkg::DRIFT_W-1:0] drift_new;

  // Running sum and sample count of the run.
  assign sum_next       = rate_sum + ghi_pkg::SUM_W'(rate);
  assign cal_count_next = cal_count + 1'b1;
  assign run_done       = cal_count_next >= RUN_LEN;

  // Mean of the run: divide the magnitude, then restore the sign.
  assign sum_mag   = sum_next[ghi_pkg::SUM_W-1] ? (~sum_next + 1'b1) : sum_next;
  assign prod      = PROD_W'(sum_mag) * PROD_W'(RECIP);
  assign quot      = prod[Q_SHIFT +: ghi_pkg::DRIFT_W];
  assign drift_new = sum_next[ghi_pkg::SUM_W-1] ? signed'(~quot + 1'b1) : signed'(quot);

  assign calibrated_next = is_calibrated || (fire && run_done);

  // Calibration state: a finished run replaces the drift and restarts.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_sum      <= '0;
      cal_count     <= '0;
      drift_q8      <= '0;
      is_calibrated <= 1'b0;
    end else if (fire) begin
      if (run_done) begin
        rate_sum      <= '0;
        cal_count     <= '0;
        drift_q8      <= drift_new;
        is_calibrated <= 1'b1;
      end else begin
        rate_sum  <= sum_next;
        cal_count <= cal_count_next;
      end
    end
  end

endmodule

// ----- hdl/ghi_integ_unit.sv -----
// ---------------------------------------------------------------------------
// ghi_integ_unit: rate integration into the heading accumulator
// Measures dt since the last update, forms the drift-corrected step,
// applies the dead-band and adds it into a saturating accumulator.
// ---------------------------------------------------------------------------
module ghi_integ_unit #(
  parameter int DT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic signed [ghi_pkg::RATE_W-1:0]  rate,
  input  logic [ghi_pkg::TS_W-1:0]           timestamp,
  input  logic signed [ghi_pkg::DRIFT_W-1:0] drift_q8,
  input  logic [ghi_pkg::THR_W-1:0]          threshold,
  output logic signed [ghi_pkg::ACC_W-1:0]   angle,
  output logic signed [ghi_pkg::ACC_W-1:0]   angle_next
);

  localparam int DIFF_W = ghi_pkg::RATE_W + 9;
  localparam int STEP_W = DIFF_W + DT_BITS + 1;
  localparam int ADD_W  = (STEP_W > ghi_pkg::ACC_W ? STEP_W : ghi_pkg::ACC_W) + 1;
  localparam int TOP_W  = ADD_W - ghi_pkg::ACC_W + 1;
  localparam logic [ghi_pkg::TS_W-1:0] DT_MAX_TS =
    ghi_pkg::TS_W'((64'd1 << DT_BITS) - 64'd1);
  localparam logic [DT_BITS-1:0] DT_MAX = '1;

  logic [ghi_pkg::TS_W-1:0]   last_time;
  logic [ghi_pkg::TS_W-1:0]   dt_raw;
  logic [DT_BITS-1:0]         dt;
  logic signed [DIFF_W-1:0]   rate_ext;
  logic signed [DIFF_W-1:0]   drift_ext;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DT_BITS:0]    dt_s;
  logic signed [STEP_W-1:0]   step;
  logic [STEP_W-1:0]          step_mag;
  logic signed [STEP_W-1:0]   step_kept;
  logic signed [ADD_W-1:0]    sum;
  logic [TOP_W-1:0]           sum_top;
  logic                       sum_ovf;
  logic signed [ghi_pkg::ACC_W-1:0] sum_sat;

  // Elapsed time since the previous update, saturated.
  assign dt_raw = timestamp - last_time;
  assign dt     = (dt_raw > DT_MAX_TS) ? DT_MAX : dt_raw[DT_BITS-1:0];

  // Drift-corrected rate in Q8 times dt.
  assign rate_ext  = {rate[ghi_pkg::RATE_W-1], rate, 8'b0};
  assign drift_ext = {drift_q8[ghi_pkg::DRIFT_W-1], drift_q8};
  assign diff      = rate_ext - drift_ext;
  assign dt_s      = signed'({1'b0, dt});
  assign step      = diff * dt_s;

  // Dead-band: steps smaller in magnitude than the threshold count as zero.
  assign step_mag  = step[STEP_W-1] ? (~step + 1'b1) : step;
  assign step_kept = (step_mag >= STEP_W'(threshold)) ? step : '0;

  // Saturating accumulate: overflow when the top bits disagree.
  assign sum     = ADD_W'(angle) + ADD_W'(step_kept);
  assign sum_top = sum[ADD_W-1 -: TOP_W];
  assign sum_ovf = (|sum_top) && !(&sum_top);
  always_comb begin
    if (!sum_ovf) begin
      sum_sat = sum[ghi_pkg::ACC_W-1:0];
    end else if (sum[ADD_W-1]) begin
      sum_sat = {1'b1, {(ghi_pkg::ACC_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(ghi_pkg::ACC_W-1){1'b1}}};
    end
  end

  assign angle_next = fire ? sum_sat : angle;

  // Accumulator and time of the last update.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle     <= '0;
      last_time <= '0;
    end else if (fire) begin
      angle     <= sum_sat;
      last_time <= timestamp;
    end
  end

endmodule

// ----- tb/tb_gyro_heading_integrator_unit.sv -----
// ---------------------------------------------------------------------------
// tb_gyro_heading_integrator_unit: self-checking bench for the heading unit
// Drives calibration and heading update samples through the valid/ready
// channels and predicts every result with a cycle-free model of the drift
// estimate, dead-band and saturating heading accumulator. The stimulus covers
// directed corner cases, dead-band register settings, saturation at both
// limits, output back-pressure and random traffic with random idle gaps.
// ---------------------------------------------------------------------------
module tb_gyro_heading_integrator_unit;

  localparam int     RATE_W      = ghi_pkg::RATE_W;
  localparam int     TS_W        = ghi_pkg::TS_W;
  localparam int     ACC_W       = ghi_pkg::ACC_W;
  localparam int     THR_W       = ghi_pkg::THR_W;
  localparam int     CNT_W       = ghi_pkg::CNT_W;
  localparam int     CAL_RUN     = 100;
  localparam int     DT_BITS     = 16;
  localparam longint DT_MAX      = (longint'(1) << DT_BITS) - 1;
  localparam longint HEADING_MAX = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint HEADING_MIN = -(longint'(1) << (ACC_W - 1));

  typedef struct {
    logic signed [ACC_W-1:0] heading;
    logic                    calibrated;
  } heading_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     opcode;
  logic signed [RATE_W-1:0] rate_sample;
  logic [TS_W-1:0]          timestamp_ms;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [ACC_W-1:0]  heading;
  logic                     calibrated;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [THR_W-1:0]         cfg_data;

  // Predicted state of the integrator.
  int               cal_sum;
  int               cal_taken;
  longint           drift_est;
  logic             cal_done;
  logic [TS_W-1:0]  prev_update_ts;
  longint           heading_acc;
  logic [THR_W-1:0] deadband;

  heading_result_t  pending_headings[$];
  int               mismatch_count;
  bit               idle_en;
  int               hold_cycles;
  logic [TS_W-1:0]  stim_ts;

  gyro_heading_integrator_unit #(
    .CAL_SAMPLES(CAL_RUN),
    .DT_BITS    (DT_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .rate_sample (rate_sample),
    .timestamp_ms(timestamp_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .heading     (heading),
    .calibrated  (calibrated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Clock generation.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the predicted state by one accepted sample and queue its result.
  function automatic void predict_sample(input ghi_pkg::ghi_item_t sample);
    logic signed [RATE_W-1:0] rate;
    logic [TS_W-1:0]          delta;
    longint                   dt;
    longint                   step;
    longint                   mag;
    longint                   sum;
    heading_result_t          res;
    rate = sample.rate_sample;
    if (sample.opcode == ghi_pkg::OP_CALIB) begin
      cal_sum   = cal_sum + int'(rate);
      cal_taken = (cal_taken + 1) % (1 << CNT_W);
      // The last sample of a run replaces the drift with the run's mean.
      if (cal_taken >= CAL_RUN) begin
        drift_est = (longint'(cal_sum) * 256) / CAL_RUN;
        cal_done  = 1'b1;
        cal_sum   = 0;
        cal_taken = 0;
      end
    end else begin
      delta          = sample.timestamp_ms - prev_update_ts;
      dt             = (longint'(delta) > DT_MAX) ? DT_MAX : longint'(delta);
      prev_update_ts = sample.timestamp_ms;
      step = (longint'(rate) * 256 - drift_est) * dt;
      mag  = (step < 0) ? -step : step;
      if (mag < longint'(deadband)) step = 0;
      sum = heading_acc + step;
      if (sum > HEADING_MAX) sum = HEADING_MAX;
      if (sum < HEADING_MIN) sum = HEADING_MIN;
      heading_acc = sum;
    end
    res.heading    = heading_acc[ACC_W-1:0];
    res.calibrated = cal_done;
    pending_headings.push_back(res);
  endfunction

  // Send one sample; called and returning at a falling edge.
  task automatic send_sample(input logic op, input logic signed [RATE_W-1:0] rate,
                             input logic [TS_W-1:0] ts);
    ghi_pkg::ghi_item_t sample;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    sample.opcode       = op;
    sample.rate_sample  = rate;
    sample.timestamp_ms = ts;
    in_valid     = 1'b1;
    opcode       = op;
    rate_sample  = rate;
    timestamp_ms = ts;
    do @(posedge clk); while (!in_ready);
    predict_sample(sample);
    @(negedge clk);
  endtask

  // Write the dead-band threshold while the block is idle.
  task automatic write_deadband(input logic [THR_W-1:0] value);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    deadband = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold off the sender until every queued result has been checked.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_headings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mixed traffic: calibration bursts around a bias, regular updates with
  // small time steps, and fully random samples.
  task automatic random_phase(input int count);
    int                       sent;
    int                       kind;
    int                       burst;
    int                       k;
    logic signed [RATE_W-1:0] bias;
    logic signed [RATE_W-1:0] rate;
    logic [31:0]              r;
    sent = 0;
    bias = RATE_W'($urandom_range(0, 4000)) - RATE_W'(2000);
    while (sent < count) begin
      kind  = $urandom_range(0, 9);
      burst = $urandom_range(3, 30);
      if (kind == 0) bias = RATE_W'($urandom_range(0, 4000)) - RATE_W'(2000);
      for (k = 0; k < burst && sent < count; k++) begin
        r    = $urandom();
        rate = bias + RATE_W'($urandom_range(0, 64)) - RATE_W'(32);
        if (kind < 4) begin
          send_sample(ghi_pkg::OP_CALIB, rate, $urandom());
        end else if (kind < 8) begin
          if (r[31:29] == 3'd0) rate = r[15:0];
          stim_ts = stim_ts + $urandom_range(0, 40);
          send_sample(ghi_pkg::OP_UPDATE, rate, stim_ts);
        end else begin
          stim_ts = $urandom();
          send_sample(r[31], r[15:0], stim_ts);
        end
        sent++;
      end
    end
  endtask

  // Directed corner cases with the reset threshold.
  task automatic test_directed();
    // First update measures dt from zero, and no drift is removed yet.
    send_sample(ghi_pkg::OP_UPDATE, 16'sd1000, 32'd10);
    send_sample(ghi_pkg::OP_UPDATE, 16'sd1, 32'd11);
    // Steps exactly at and just under the dead-band threshold.
    send_sample(ghi_pkg::OP_UPDATE, 16'sd6550, 32'd12);
    send_sample(ghi_pkg::OP_UPDATE, 16'sd6549, 32'd13);
    send_sample(ghi_pkg::OP_UPDATE, -16'sd6550, 32'd14);
    // Zero elapsed time gives a zero step.
    send_sample(ghi_pkg::OP_UPDATE, 16'sh7FFF, 32'd14);
    // Calibration samples leave the heading and the update time alone.
    send_sample(ghi_pkg::OP_CALIB, 16'sh7FFF, 32'hFFFF_FFFF);
    send_sample(ghi_pkg::OP_CALIB, 16'sh8000, 32'd0);
    send_sample(ghi_pkg::OP_UPDATE, 16'sd0, 32'd17);
    // A timestamp going backwards saturates dt.
    send_sample(ghi_pkg::OP_UPDATE, 16'sh7FFF, 32'd5);
    send_sample(ghi_pkg::OP_UPDATE, 16'sh8000, 32'hFFFF_FFFF);
    // Timestamp wrap gives dt of one.
    send_sample(ghi_pkg::OP_UPDATE, 16'sd100, 32'd0);
    send_sample(ghi_pkg::OP_UPDATE, -16'sd1, 32'h0001_0000);
    send_sample(ghi_pkg::OP_UPDATE, 16'sd0, 32'h0001_0001);
    stim_ts = 32'h0001_0001;
  endtask

  // Dead-band register at its extremes.
  task automatic test_deadband_register();
    wait_idle();
    write_deadband('0);
    send_sample(ghi_pkg::OP_UPDATE, 16'sd1, stim_ts + 32'd1);
    send_sample(ghi_pkg::OP_UPDATE, 16'sd0, stim_ts + 32'd2);
    stim_ts = stim_ts + 32'd2;
    wait_idle();
    write_deadband({THR_W{1'b1}});
    send_sample(ghi_pkg::OP_UPDATE, 16'sh7FFF, stim_ts + 32'd1);
    send_sample(ghi_pkg::OP_UPDATE, 16'sh7FFF, stim_ts + 32'd3);
    send_sample(ghi_pkg::OP_UPDATE, 16'sh7FFF, stim_ts + 32'd6);
    send_sample(ghi_pkg::OP_UPDATE, 16'sh8000, stim_ts + 32'd8);
    stim_ts = stim_ts + 32'd8;
    wait_idle();
    write_deadband(ghi_pkg::THR_RESET);
  endtask

  // Drive the heading into both saturation limits through extreme drifts.
  task automatic test_heading_saturation();
    int guard;
    // Finish the open calibration run with the most negative rate, which
    // leaves a drift close to the negative extreme.
    idle_en = 1'b0;
    repeat (CAL_RUN - cal_taken) send_sample(ghi_pkg::OP_CALIB, 16'sh8000, $urandom());
    guard = 0;
    while (heading_acc != HEADING_MAX && guard < 400) begin
      stim_ts = stim_ts + 32'd70000;
      send_sample(ghi_pkg::OP_UPDATE, 16'sh7FFF, stim_ts);
      guard++;
    end
    idle_en = 1'b1;
    repeat (3) begin
      stim_ts = stim_ts + 32'd70000;
      send_sample(ghi_pkg::OP_UPDATE, 16'sh7FFF, stim_ts);
    end
    // Recalibration replaces the drift with the opposite extreme.
    repeat (CAL_RUN) send_sample(ghi_pkg::OP_CALIB, 16'sh7FFF, $urandom());
    guard = 0;
    while (heading_acc != HEADING_MIN && guard < 600) begin
      stim_ts = stim_ts - 32'd1;
      send_sample(ghi_pkg::OP_UPDATE, 16'sh8000, stim_ts);
      guard++;
    end
    repeat (3) begin
      stim_ts = stim_ts + 32'd70000;
      send_sample(ghi_pkg::OP_UPDATE, 16'sh8000, stim_ts);
    end
  endtask

  // The receiver stalls for a long stretch while samples keep coming.
  task automatic test_backpressure();
    hold_cycles = 80;
    random_phase(20);
    wait_idle();
  endtask

  // Random traffic under several dead-band settings.
  task automatic test_random_traffic();
    int               phase;
    logic [THR_W-1:0] thr;
    for (phase = 0; phase < 3; phase++) begin
      wait_idle();
      thr = THR_W'($urandom());
      if (phase == 0) thr = thr >> 10;
      write_deadband(thr);
      random_phase(40);
    end
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_streaming();
    wait_idle();
    write_deadband(ghi_pkg::THR_RESET);
    idle_en = 1'b0;
    random_phase(40);
  endtask

  // Result receiver: random stall bursts plus an optional long hold-off.
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready  = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin
    heading_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_headings.size() == 0) begin
        $error("unexpected result: heading %0d calibrated %0b", heading, calibrated);
        mismatch_count++;
      end else begin
        want = pending_headings.pop_front();
        if (heading !== want.heading) begin
          $error("heading mismatch: expected %0d, actual %0d", want.heading, heading);
          mismatch_count++;
        end
        if (calibrated !== want.calibrated) begin
          $error("calibrated mismatch: expected %0b, actual %0b", want.calibrated,
                 calibrated);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int guard;
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = ghi_pkg::OP_CALIB;
    rate_sample    = '0;
    timestamp_ms   = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    cal_sum        = 0;
    cal_taken      = 0;
    drift_est      = 0;
    cal_done       = 1'b0;
    prev_update_ts = '0;
    heading_acc    = 0;
    deadband       = ghi_pkg::THR_RESET;
    mismatch_count = 0;
    idle_en        = 1'b1;
    hold_cycles    = 0;
    stim_ts        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_deadband_register();
    test_heading_saturation();
    test_backpressure();
    test_random_traffic();
    test_streaming();

    // Drain the remaining results, then allow for the pipeline depth.
    in_valid = 1'b0;
    guard    = 0;
    while (pending_headings.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (pending_headings.size() != 0) begin
      $error("%0d expected results never arrived", pending_headings.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ghi_pkg.sv
hdl/ghi_input_stage.sv
hdl/ghi_calib_unit.sv
hdl/ghi_integ_unit.sv
hdl/gyro_heading_integrator_unit.sv
tb/tb_gyro_heading_integrator_unit.sv
